FILE: design/sttc_pkg.sv
// Shared widths, register codes, command types and fixed-point helpers for the tone control.
package sttc_pkg;

  localparam int SAMPLE_W   = 24;
  localparam int STATE_W    = 40;
  localparam int COEF_W     = 32;
  localparam int GAIN_W     = 24;
  localparam int CFG_W      = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int COEF_SHIFT = 28;
  localparam int GAIN_SHIFT = 20;
  localparam int FRAC_SHIFT = (STATE_W - 4) - (SAMPLE_W - 1);
  localparam int SPLIT_W    = 32;
  localparam int HI_W       = STATE_W - SPLIT_W;
  localparam int PL_W       = SPLIT_W + 1 + COEF_W;
  localparam int PH_W       = HI_W + COEF_W;
  localparam int PROD_W     = STATE_W + COEF_W;
  localparam int MUL_W      = STATE_W + 6;
  localparam int WIDE_W     = MUL_W + 4;
  localparam int STEP_W     = 4;

  localparam logic signed [COEF_W-1:0] RST_TREBLE_B0 = 32'sd14776700;
  localparam logic signed [COEF_W-1:0] RST_TREBLE_A1 = -32'sd250378000;
  localparam logic signed [COEF_W-1:0] RST_TREBLE_A2 = 32'sd41048600;
  localparam logic signed [COEF_W-1:0] RST_BASS_B0   = 32'sd27458000;
  localparam logic signed [COEF_W-1:0] RST_BASS_A1   = -32'sd49118000;
  localparam logic signed [COEF_W-1:0] RST_BASS_A2   = -32'sd109487000;
  localparam logic [GAIN_W-1:0]        RST_GAIN      = 24'd1048576;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TREBLE_B0   = 3'd0,
    REG_TREBLE_A1   = 3'd1,
    REG_TREBLE_A2   = 3'd2,
    REG_BASS_B0     = 3'd3,
    REG_BASS_A1     = 3'd4,
    REG_BASS_A2     = 3'd5,
    REG_TREBLE_GAIN = 3'd6,
    REG_BASS_GAIN   = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    OP_TB0 = 3'd0,
    OP_BB0 = 3'd1,
    OP_TA1 = 3'd2,
    OP_TA2 = 3'd3,
    OP_BA1 = 3'd4,
    OP_BA2 = 3'd5,
    OP_TG  = 3'd6,
    OP_BG  = 3'd7
  } mul_op_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] t_b0;
    logic signed [COEF_W-1:0] t_a1;
    logic signed [COEF_W-1:0] t_a2;
    logic signed [COEF_W-1:0] b_b0;
    logic signed [COEF_W-1:0] b_a1;
    logic signed [COEF_W-1:0] b_a2;
    logic [GAIN_W-1:0]        t_gain;
    logic [GAIN_W-1:0]        b_gain;
  } coef_t;

  typedef struct packed {
    logic    load_in;
    mul_op_t op;
    logic    wr_pt;
    logic    wr_pb;
    logic    wr_tb;
    logic    wr_s1t;
    logic    wr_s2t;
    logic    wr_s1b;
    logic    wr_s2b;
    logic    wr_tg;
    logic    wr_res;
    logic    swap;
    logic    load_out;
  } cmd_t;

  function automatic logic signed [STATE_W-1:0] sat_st(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-STATE_W:0] top;
    top = v[WIDE_W-1:STATE_W-1];
    if (top == '0 || top == '1) begin
      return v[STATE_W-1:0];
    end else if (v[WIDE_W-1]) begin
      return {1'b1, {(STATE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(STATE_W-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [WIDE_W-1:0] wext(input logic signed [STATE_W-1:0] v);
    return {{(WIDE_W-STATE_W){v[STATE_W-1]}}, v};
  endfunction

  function automatic logic signed [WIDE_W-1:0] mext(input logic signed [MUL_W-1:0] v);
    return {{(WIDE_W-MUL_W){v[MUL_W-1]}}, v};
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] to_sample(input logic signed [STATE_W-1:0] v);
    logic signed [STATE_W-1:0] t;
    logic [STATE_W-SAMPLE_W:0] top;
    t   = v >>> FRAC_SHIFT;
    top = t[STATE_W-1:SAMPLE_W-1];
    if (top == '0 || top == '1) begin
      return t[SAMPLE_W-1:0];
    end else if (t[STATE_W-1]) begin
      return {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      return {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

endpackage

FILE: design/sttc_cfg.sv
// Coefficient and gain register bank, written through the configuration port.
module sttc_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [sttc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sttc_pkg::CFG_W-1:0]     cfg_data,
  output sttc_pkg::coef_t                coef
);
  import sttc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.t_b0   <= RST_TREBLE_B0;
      coef.t_a1   <= RST_TREBLE_A1;
      coef.t_a2   <= RST_TREBLE_A2;
      coef.b_b0   <= RST_BASS_B0;
      coef.b_a1   <= RST_BASS_A1;
      coef.b_a2   <= RST_BASS_A2;
      coef.t_gain <= RST_GAIN;
      coef.b_gain <= RST_GAIN;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TREBLE_B0:   coef.t_b0   <= cfg_data[COEF_W-1:0];
        REG_TREBLE_A1:   coef.t_a1   <= cfg_data[COEF_W-1:0];
        REG_TREBLE_A2:   coef.t_a2   <= cfg_data[COEF_W-1:0];
        REG_BASS_B0:     coef.b_b0   <= cfg_data[COEF_W-1:0];
        REG_BASS_A1:     coef.b_a1   <= cfg_data[COEF_W-1:0];
        REG_BASS_A2:     coef.b_a2   <= cfg_data[COEF_W-1:0];
        REG_TREBLE_GAIN: coef.t_gain <= cfg_data[GAIN_W-1:0];
        REG_BASS_GAIN:   coef.b_gain <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

FILE: design/sttc_ctrl.sv
// Sequencer: request handshake and the per-sample step schedule driving both lanes.
module sttc_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output sttc_pkg::cmd_t cmd
);
  import sttc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_RUN  = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  localparam logic [STEP_W-1:0] STP_MUL_TB0 = 4'd0;
  localparam logic [STEP_W-1:0] STP_MUL_BB0 = 4'd1;
  localparam logic [STEP_W-1:0] STP_Y_TREB  = 4'd2;
  localparam logic [STEP_W-1:0] STP_Y_BASS  = 4'd3;
  localparam logic [STEP_W-1:0] STP_MUL_TA2 = 4'd4;
  localparam logic [STEP_W-1:0] STP_S1_TREB = 4'd5;
  localparam logic [STEP_W-1:0] STP_S2_TREB = 4'd6;
  localparam logic [STEP_W-1:0] STP_S1_BASS = 4'd7;
  localparam logic [STEP_W-1:0] STP_S2_BASS = 4'd8;
  localparam logic [STEP_W-1:0] STP_TG      = 4'd9;
  localparam logic [STEP_W-1:0] STP_SUM     = 4'd10;

  state_t            state, state_next;
  logic [STEP_W-1:0] step, step_next;
  logic              out_valid_next;

  always_comb begin
    cmd         = '0;
    cmd.op      = OP_TB0;
    cmd.load_in = (state == S_IDLE) && in_valid;
    if (state == S_RUN) begin
      case (step)
        STP_MUL_TB0: cmd.op = OP_TB0;
        STP_MUL_BB0: cmd.op = OP_BB0;
        STP_Y_TREB:  cmd.wr_pt = 1'b1;
        STP_Y_BASS: begin
          cmd.wr_pb = 1'b1;
          cmd.wr_tb = 1'b1;
          cmd.op    = OP_TA1;
        end
        STP_MUL_TA2: cmd.op = OP_TA2;
        STP_S1_TREB: begin
          cmd.wr_s1t = 1'b1;
          cmd.op     = OP_BA1;
        end
        STP_S2_TREB: begin
          cmd.wr_s2t = 1'b1;
          cmd.op     = OP_BA2;
        end
        STP_S1_BASS: begin
          cmd.wr_s1b = 1'b1;
          cmd.op     = OP_TG;
        end
        STP_S2_BASS: begin
          cmd.wr_s2b = 1'b1;
          cmd.op     = OP_BG;
        end
        STP_TG:  cmd.wr_tg = 1'b1;
        STP_SUM: begin
          cmd.wr_res = 1'b1;
          cmd.swap   = 1'b1;
        end
        default: ;
      endcase
    end
    cmd.load_out = (state == S_HOLD) && (!out_valid || out_ready);
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      S_IDLE: begin
        step_next = '0;
        if (in_valid) state_next = S_RUN;
      end
      S_RUN: begin
        if (step == STP_SUM) begin
          state_next = S_HOLD;
        end else begin
          step_next = step + 1'b1;
        end
      end
      S_HOLD: begin
        if (cmd.load_out) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.load_out) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  assign in_ready = (state == S_IDLE);

endmodule

FILE: design/sttc_lane.sv
// One channel datapath: shared split multiplier, two lowpass sections, band mix, output register.
module sttc_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  sttc_pkg::cmd_t                      cmd,
  input  sttc_pkg::coef_t                     coef,
  input  logic signed [sttc_pkg::SAMPLE_W-1:0] sample_in,
  output logic signed [sttc_pkg::SAMPLE_W-1:0] sample_out
);
  import sttc_pkg::*;

  localparam logic [1:0] IDX_S1T = 2'd0;
  localparam logic [1:0] IDX_S2T = 2'd1;
  localparam logic [1:0] IDX_S1B = 2'd2;
  localparam logic [1:0] IDX_S2B = 2'd3;

  logic signed [SAMPLE_W-1:0] x_s;
  logic signed [STATE_W-1:0]  x_ext;
  logic signed [STATE_W-1:0]  x_i;

  // live set and the set used by the other phase; swapped after every sample
  logic signed [STATE_W-1:0]  cur [4];
  logic signed [STATE_W-1:0]  alt [4];

  logic signed [MUL_W-1:0]    pt, pb;
  logic signed [STATE_W-1:0]  yt, yb, tb, tg;
  logic signed [SAMPLE_W-1:0] res;

  logic signed [STATE_W-1:0]  m_a;
  logic signed [COEF_W-1:0]   m_c;
  logic                       m_gain;
  logic signed [SPLIT_W:0]    m_lo;
  logic signed [HI_W-1:0]     m_hi;
  logic signed [PL_W-1:0]     pl;
  logic signed [PH_W-1:0]     ph;
  logic                       gain_q;
  logic signed [PROD_W-1:0]   full;
  logic signed [PROD_W-1:0]   shifted;
  logic signed [MUL_W-1:0]    r;
  logic signed [STATE_W-1:0]  bg;
  logic signed [STATE_W-1:0]  sum;

  assign x_ext = {{(STATE_W-SAMPLE_W){x_s[SAMPLE_W-1]}}, x_s};
  assign x_i   = x_ext <<< FRAC_SHIFT;

  always_comb begin
    m_a    = x_i;
    m_c    = coef.t_b0;
    m_gain = 1'b0;
    case (cmd.op)
      OP_TB0: begin m_a = x_i; m_c = coef.t_b0; end
      OP_BB0: begin m_a = x_i; m_c = coef.b_b0; end
      OP_TA1: begin m_a = yt;  m_c = coef.t_a1; end
      OP_TA2: begin m_a = yt;  m_c = coef.t_a2; end
      OP_BA1: begin m_a = yb;  m_c = coef.b_a1; end
      OP_BA2: begin m_a = yb;  m_c = coef.b_a2; end
      OP_TG: begin
        m_a    = tb;
        m_c    = {{(COEF_W-GAIN_W){1'b0}}, coef.t_gain};
        m_gain = 1'b1;
      end
      OP_BG: begin
        m_a    = yb;
        m_c    = {{(COEF_W-GAIN_W){1'b0}}, coef.b_gain};
        m_gain = 1'b1;
      end
      default: ;
    endcase
  end

  assign m_lo = {1'b0, m_a[SPLIT_W-1:0]};
  assign m_hi = m_a[STATE_W-1:SPLIT_W];

  always_ff @(posedge clk) begin
    pl     <= PL_W'(m_lo) * PL_W'(m_c);
    ph     <= PH_W'(m_hi) * PH_W'(m_c);
    gain_q <= m_gain;
  end

  // recombine the partial products, floor to the coefficient or gain scale
  assign full    = {ph, {SPLIT_W{1'b0}}} + {{(PROD_W-PL_W){pl[PL_W-1]}}, pl};
  assign shifted = gain_q ? (full >>> GAIN_SHIFT) : (full >>> COEF_SHIFT);

  always_ff @(posedge clk) begin
    r <= shifted[MUL_W-1:0];
  end

  assign bg  = sat_st(mext(r));
  assign sum = sat_st(wext(bg) + wext(tg));

  always_ff @(posedge clk) begin
    if (cmd.load_in) x_s <= sample_in;
    if (cmd.wr_pt) begin
      pt <= r;
      yt <= sat_st(mext(r) + wext(cur[IDX_S1T]));
    end
    if (cmd.wr_pb) begin
      pb <= r;
      yb <= sat_st(mext(r) + wext(cur[IDX_S1B]));
    end
    if (cmd.wr_tb) tb <= sat_st(wext(x_i) - wext(yt));
    if (cmd.wr_tg) tg <= sat_st(mext(r));
    if (cmd.wr_res) res <= to_sample(sum);
    if (cmd.load_out) sample_out <= res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        cur[i] <= '0;
        alt[i] <= '0;
      end
    end else if (cmd.swap) begin
      for (int i = 0; i < 4; i++) begin
        cur[i] <= alt[i];
        alt[i] <= cur[i];
      end
    end else begin
      if (cmd.wr_s1t) cur[IDX_S1T] <= sat_st((mext(pt) <<< 1) - mext(r) + wext(cur[IDX_S2T]));
      if (cmd.wr_s2t) cur[IDX_S2T] <= sat_st(mext(pt) - mext(r));
      if (cmd.wr_s1b) cur[IDX_S1B] <= sat_st((mext(pb) <<< 1) - mext(r) + wext(cur[IDX_S2B]));
      if (cmd.wr_s2b) cur[IDX_S2B] <= sat_st(mext(pb) - mext(r));
    end
  end

endmodule

FILE: design/stereo_two_band_tone_control_top.sv
// Top level of the stereo two-band tone control: register bank, sequencer and two channel lanes.
//
// Usage:
//   Input channel: in_valid/in_ready carry one stereo request (left_in, right_in,
//   signed Q1.23). Output channel: out_valid/out_ready carry the matching
//   tone-controlled pair (left_out, right_out), saturated to the sample width.
//   Configuration: cfg_we writes cfg_data into register cfg_index (treble and bass
//   lowpass coefficients in Q4.28, band gains in unsigned Q4.20);
//   write only while no request is in flight.
// Timing:
//   One request is worked on at a time. After acceptance the lanes step through an
//   eleven-step schedule of eight products per channel on one split multiplier each,
//   each product registered first as partial products and then as the recombined
//   product; the result is then loaded into the output register, and the sequencer
//   returns to idle, where the next request is taken.
// Stall and reset:
//   A waiting result sits in the output register; a finished request parks until
//   the output register frees, and no new request is taken meanwhile.
//   Reset loads the default coefficients, clears all filter state and both
//   alternating state sets, and empties the output register.
module stereo_two_band_tone_control_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [sttc_pkg::SAMPLE_W-1:0] left_in,
  input  logic signed [sttc_pkg::SAMPLE_W-1:0] right_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [sttc_pkg::SAMPLE_W-1:0] left_out,
  output logic signed [sttc_pkg::SAMPLE_W-1:0] right_out,
  input  logic                                 cfg_we,
  input  logic [sttc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sttc_pkg::CFG_W-1:0]           cfg_data
);
  import sttc_pkg::*;

  coef_t coef;
  cmd_t  cmd;

  sttc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .coef      (coef)
  );

  sttc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sttc_lane u_left (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .coef       (coef),
    .sample_in  (left_in),
    .sample_out (left_out)
  );

  sttc_lane u_right (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .coef       (coef),
    .sample_in  (right_in),
    .sample_out (right_out)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while a previous one is still being processed");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result presented without a request having been processed");

endmodule

FILE: tb/tb_stereo_two_band_tone_control_top.sv
// Self-checking testbench for the stereo two-band tone control with its own fixed-point predictor.
module tb_stereo_two_band_tone_control_top;
  import sttc_pkg::*;

  typedef logic signed [95:0] wide_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
  } tone_pair_t;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int UNITY_COEF     = 1 << COEF_SHIFT;
  localparam int UNITY_GAIN     = 1 << GAIN_SHIFT;
  localparam int A2_SPAN        = 241591910;

  localparam logic signed [SAMPLE_W-1:0] FULL_POS = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] FULL_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};

  localparam coef_t DEFAULT_COEFS = '{
    t_b0: RST_TREBLE_B0, t_a1: RST_TREBLE_A1, t_a2: RST_TREBLE_A2,
    b_b0: RST_BASS_B0, b_a1: RST_BASS_A1, b_a2: RST_BASS_A2,
    t_gain: RST_GAIN, b_gain: RST_GAIN
  };

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       in_valid  = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] left_in   = '0;
  logic signed [SAMPLE_W-1:0] right_in  = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic                       cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_W-1:0]           cfg_data  = '0;

  // predictor state
  coef_t                     tone_cfg = DEFAULT_COEFS;
  logic signed [STATE_W-1:0] tone_mem [16];
  logic                      tone_set = 1'b0;
  tone_pair_t                tone_due [$];

  int src_max   = 0;
  int sink_max  = 0;
  int sink_hold = 0;
  int quiet     = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int n_setting = 0;
  int n_errors  = 0;

  stereo_two_band_tone_control_top u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .left_in   (left_in),
    .right_in  (right_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .left_out  (left_out),
    .right_out (right_out),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic wide_t clamp_to(input wide_t v, input int bits);
    wide_t hi;
    wide_t lo;
    hi = (wide_t'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // exact product, floored by sh bits
  function automatic wide_t scaled(input logic signed [STATE_W-1:0] v, input longint c,
                                   input int sh);
    wide_t wv;
    wide_t wc;
    wv = wide_t'(v);
    wc = wide_t'(c);
    return (wv * wc) >>> sh;
  endfunction

  function automatic logic signed [STATE_W-1:0] lowpass(input logic signed [STATE_W-1:0] x,
                                                        input int at,
                                                        input logic [COEF_W-1:0] b0, a1, a2);
    wide_t                     p;
    wide_t                     s1;
    wide_t                     s2;
    logic signed [STATE_W-1:0] y;
    s1 = wide_t'(tone_mem[at]);
    s2 = wide_t'(tone_mem[at+1]);
    p  = scaled(x, longint'($signed(b0)), COEF_SHIFT);
    y  = STATE_W'(clamp_to(p + s1, STATE_W));
    tone_mem[at]   = STATE_W'(clamp_to(p + p - scaled(y, longint'($signed(a1)), COEF_SHIFT)
                                       + s2, STATE_W));
    tone_mem[at+1] = STATE_W'(clamp_to(p - scaled(y, longint'($signed(a2)), COEF_SHIFT),
                                       STATE_W));
    return y;
  endfunction

  task automatic predict_tone(input logic signed [SAMPLE_W-1:0] l, r);
    logic signed [SAMPLE_W-1:0] smp [2];
    logic signed [SAMPLE_W-1:0] res [2];
    logic signed [STATE_W-1:0]  x, yt, yb, tb, tg, bg, sum;
    wide_t                      t;
    int                         at;
    int                         ch;
    smp[0] = l;
    smp[1] = r;
    for (ch = 0; ch < 2; ch++) begin
      x  = STATE_W'(smp[ch]);
      x  = x <<< FRAC_SHIFT;
      at = (tone_set ? 8 : 0) + ch * 4;
      yt = lowpass(x, at, tone_cfg.t_b0, tone_cfg.t_a1, tone_cfg.t_a2);
      yb = lowpass(x, at + 2, tone_cfg.b_b0, tone_cfg.b_a1, tone_cfg.b_a2);
      t  = wide_t'(x);
      tb = STATE_W'(clamp_to(t - yt, STATE_W));
      tg = STATE_W'(clamp_to(scaled(tb, longint'(tone_cfg.t_gain), GAIN_SHIFT), STATE_W));
      bg = STATE_W'(clamp_to(scaled(yb, longint'(tone_cfg.b_gain), GAIN_SHIFT), STATE_W));
      t  = wide_t'(tg);
      sum = STATE_W'(clamp_to(t + bg, STATE_W));
      t  = wide_t'(sum);
      res[ch] = SAMPLE_W'(clamp_to(t >>> FRAC_SHIFT, SAMPLE_W));
    end
    tone_set = ~tone_set;
    tone_due.push_back('{left: res[0], right: res[1]});
  endtask

  task automatic report_mismatch(input string what, input logic [SAMPLE_W-1:0] got, want);
    $display("[%0t] mismatch %s: got %06h want %06h", $realtime, what, got, want);
    n_errors++;
  endtask

  task automatic send_pair(input logic signed [SAMPLE_W-1:0] l, r);
    int gap;
    gap = $urandom_range(src_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    left_in  <= l;
    right_in <= r;
    do @(posedge clk); while (!in_ready);
    predict_tone(l, r);
    n_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (tone_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_TREBLE_B0:   tone_cfg.t_b0   = data;
      REG_TREBLE_A1:   tone_cfg.t_a1   = data;
      REG_TREBLE_A2:   tone_cfg.t_a2   = data;
      REG_BASS_B0:     tone_cfg.b_b0   = data;
      REG_BASS_A1:     tone_cfg.b_a1   = data;
      REG_BASS_A2:     tone_cfg.b_a2   = data;
      REG_TREBLE_GAIN: tone_cfg.t_gain = data[GAIN_W-1:0];
      REG_BASS_GAIN:   tone_cfg.b_gain = data[GAIN_W-1:0];
      default: ;
    endcase
  endtask

  // gain writes carry junk above the gain width
  task automatic load_coefs(input coef_t c);
    write_reg(REG_TREBLE_B0, c.t_b0);
    write_reg(REG_TREBLE_A1, c.t_a1);
    write_reg(REG_TREBLE_A2, c.t_a2);
    write_reg(REG_BASS_B0, c.b_b0);
    write_reg(REG_BASS_A1, c.b_a1);
    write_reg(REG_BASS_A2, c.b_a2);
    write_reg(REG_TREBLE_GAIN, {8'($urandom), c.t_gain});
    write_reg(REG_BASS_GAIN, {8'($urandom), c.b_gain});
    cfg_we <= 1'b0;
    @(posedge clk);
    n_setting++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(9, 0))
      0:       return FULL_POS;
      1:       return FULL_NEG;
      2, 3:    return SAMPLE_W'(int'($urandom_range(8191, 0)) - 4096);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // stable sections keep |a2| < 0.9 and |a1| inside the stability triangle
  function automatic coef_t random_coefs(input bit wild);
    coef_t             c;
    logic [COEF_W-1:0] sec [6];
    int                a2v;
    int                lim;
    int                k;
    for (k = 0; k < 2; k++) begin
      if (wild) begin
        sec[3*k]   = $urandom;
        sec[3*k+1] = $urandom;
        sec[3*k+2] = $urandom;
      end else begin
        a2v = int'($urandom_range(2 * A2_SPAN, 0)) - A2_SPAN;
        lim = ((UNITY_COEF + a2v) / 20) * 19;
        sec[3*k]   = $urandom_range(UNITY_COEF / 8, 0);
        sec[3*k+1] = int'($urandom_range(2 * lim, 0)) - lim;
        sec[3*k+2] = a2v;
      end
    end
    c.t_b0 = sec[0];
    c.t_a1 = sec[1];
    c.t_a2 = sec[2];
    c.b_b0 = sec[3];
    c.b_a1 = sec[4];
    c.b_a2 = sec[5];
    c.t_gain = (wild || $urandom_range(3, 0) == 0) ? GAIN_W'($urandom)
                                                   : GAIN_W'($urandom_range(2 * UNITY_GAIN, 0));
    c.b_gain = (wild || $urandom_range(3, 0) == 0) ? GAIN_W'($urandom)
                                                   : GAIN_W'($urandom_range(2 * UNITY_GAIN, 0));
    return c;
  endfunction

  task automatic run_random(input coef_t c, input int count, input int src_lim, sink_lim);
    int i;
    drain_results();
    load_coefs(c);
    src_max  = src_lim;
    sink_max = sink_lim;
    for (i = 0; i < count; i++) begin
      if (i == count / 2 || $urandom_range(199, 0) == 0) drain_results();
      send_pair(rand_sample(), rand_sample());
    end
  endtask

  task automatic test_reset_defaults();
    src_max  = 0;
    sink_max = 0;
    send_pair(0, 0);
    send_pair(FULL_POS, FULL_NEG);
    send_pair(FULL_NEG, FULL_POS);
    send_pair(-1, 1);
    send_pair(FULL_POS, FULL_POS);
    send_pair(FULL_NEG, FULL_NEG);
    send_pair(24'h555555, 24'hAAAAAA);
    send_pair(0, 0);
  endtask

  task automatic test_gain_extremes();
    coef_t c;
    c = DEFAULT_COEFS;
    c.t_gain = '1;
    c.b_gain = '1;
    drain_results();
    load_coefs(c);
    src_max  = 12;
    sink_max = 12;
    send_pair(FULL_POS, FULL_POS);
    send_pair(FULL_NEG, FULL_NEG);
    send_pair(1, -1);
    send_pair(0, 0);
    c.t_gain = '0;
    c.b_gain = '0;
    drain_results();
    load_coefs(c);
    send_pair(FULL_POS, FULL_NEG);
    send_pair(FULL_NEG, FULL_POS);
    send_pair(0, 0);
  endtask

  // runaway feedback: every state word pinned at the internal limits
  task automatic test_unstable_saturation();
    coef_t c;
    int    i;
    c.t_b0 = {1'b0, {(COEF_W-1){1'b1}}};
    c.t_a1 = {1'b1, {(COEF_W-1){1'b0}}};
    c.t_a2 = {1'b1, {(COEF_W-1){1'b0}}};
    c.b_b0 = {1'b1, {(COEF_W-1){1'b0}}};
    c.b_a1 = {1'b0, {(COEF_W-1){1'b1}}};
    c.b_a2 = {1'b0, {(COEF_W-1){1'b1}}};
    c.t_gain = '1;
    c.b_gain = '1;
    drain_results();
    load_coefs(c);
    for (i = 0; i < 8; i++) begin
      send_pair(i[0] ? FULL_NEG : FULL_POS, i[1] ? FULL_POS : FULL_NEG);
    end
  endtask

  task automatic test_random_stable();
    run_random(random_coefs(1'b0), 350, 12, 12);
    run_random(random_coefs(1'b0), 350, 0, 0);
    run_random(random_coefs(1'b0), 350, 3, 12);
    run_random(random_coefs(1'b0), 350, 12, 0);
  endtask

  task automatic test_random_wild();
    run_random(random_coefs(1'b1), 150, 12, 12);
    run_random(random_coefs(1'b1), 150, 2, 2);
  endtask

  task automatic test_back_to_defaults();
    run_random(DEFAULT_COEFS, 100, 12, 12);
  endtask

  // result check; out_ready held low for a random stretch after each result
  always @(posedge clk) begin
    tone_pair_t want;
    if (rst) begin
      sink_hold = 0;
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (tone_due.size() == 0) begin
          report_mismatch("unexpected result", left_out, '0);
        end else begin
          want = tone_due.pop_front();
          if (left_out !== want.left) report_mismatch("left_out", left_out, want.left);
          if (right_out !== want.right) report_mismatch("right_out", right_out, want.right);
        end
        n_checked++;
        sink_hold = $urandom_range(sink_max, 0);
      end else if (sink_hold > 0) begin
        sink_hold--;
      end
      out_ready <= (sink_hold == 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", quiet);
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    for (int i = 0; i < 16; i++) tone_mem[i] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_gain_extremes();
    test_unstable_saturation();
    test_random_stable();
    test_random_wild();
    test_back_to_defaults();
    drain_results();
    $display("Run covered %0d stereo requests under %0d register loads after reset defaults,",
             n_sent, n_setting);
    $display("with %0d results compared and %0d mismatches.", n_checked, n_errors);
    if (n_errors == 0 && tone_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
